FILE: hw/rtl/bdc_pkg.sv
package bdc_pkg;

	localparam int DEG_W = 3;
	localparam logic [DEG_W-1:0] DEG_RESET = 3'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef struct packed {
		logic start;
		logic diff;
		logic upd;
	} bdc_ctl_t;

endpackage

FILE: hw/rtl/bdc_cmd_if.sv
interface bdc_cmd_if #(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [2:0]             point_index;
	logic [COORD_WIDTH-1:0] point_x;
	logic [COORD_WIDTH-1:0] point_y;
	logic [T_FRAC_BITS:0]   param_t;

	modport source (
		output valid, op, point_index, point_x, point_y, param_t,
		input  ready
	);
	modport sink (
		input  valid, op, point_index, point_x, point_y, param_t,
		output ready
	);
endinterface

FILE: hw/rtl/bdc_res_if.sv
interface bdc_res_if #(
	parameter int COORD_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] curve_x;
	logic [COORD_WIDTH-1:0] curve_y;

	modport source (
		output valid, curve_x, curve_y,
		input  ready
	);
	modport sink (
		input  valid, curve_x, curve_y,
		output ready
	);
endinterface

FILE: hw/rtl/bezier_de_casteljau_eval.sv
// 2D Bezier curve evaluator (de Casteljau), fixed point.
// cmd channel: op selects load or evaluate. A load writes point_x/point_y
//   into control point point_index; a load whose index exceeds the degree
//   is dropped. An evaluate carries param_t (Q1.T_FRAC_BITS, values above
//   1.0 saturate) and returns one item on the res channel.
// cfg_we/cfg_wdata write curve_degree (reset 3), only while idle; unchecked.
// Structure: one cell per control point and coordinate. Each interpolation
//   round runs in every cell at once: a difference step against the right
//   neighbor, then a multiply-round-add step.
// Flow: an evaluate of degree n runs n difference/update rounds, then the
//   done state loads the output register; cmd.ready is low until then, so
//   evaluates never overlap; one load per cycle while cmd.ready is high.
// Stall: a waiting result stays in the output register; loads and a new
//   evaluate are still accepted, and a finished evaluate waits for the slot.
// Reset: control points clear to zero, degree returns to 3, no result pending.
module bezier_de_casteljau_eval import bdc_pkg::*; #(
	parameter int MAX_DEGREE  = 7,
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DEG_W-1:0] cfg_wdata,
	bdc_cmd_if.sink          cmd,
	bdc_res_if.source        res
);

	localparam int EFF_MAX = (MAX_DEGREE > 7) ? 7 : MAX_DEGREE;
	localparam int NCELL   = EFF_MAX + 1;
	localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIFF = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [DEG_W-1:0]       deg_q;
	logic [DEG_W-1:0]       cnt_q;
	logic [T_FRAC_BITS:0]   t_q;
	logic                   res_valid_q;
	logic [COORD_WIDTH-1:0] res_x_q;
	logic [COORD_WIDTH-1:0] res_y_q;

	logic [DEG_W-1:0]       deg_eff;
	logic                   acc;
	logic                   load_acc;
	logic                   eval_acc;
	logic                   res_load;
	logic [T_FRAC_BITS:0]   t_sat;
	bdc_ctl_t               ctl;

	logic [COORD_WIDTH-1:0] wx [NCELL];
	logic [COORD_WIDTH-1:0] wy [NCELL];

	assign deg_eff  = (deg_q > DEG_W'(EFF_MAX)) ? DEG_W'(EFF_MAX) : deg_q;
	assign cmd.ready = (state_q == ST_IDLE);
	assign acc      = cmd.valid && cmd.ready;
	assign load_acc = acc && (cmd.op == OP_LOAD) && (cmd.point_index <= deg_eff);
	assign eval_acc = acc && (cmd.op == OP_EVAL);
	assign t_sat    = (cmd.param_t > T_ONE) ? T_ONE : cmd.param_t;
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	assign ctl.start = eval_acc;
	assign ctl.diff  = (state_q == ST_DIFF);
	assign ctl.upd   = (state_q == ST_UPD);

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		logic wr_en;
		assign wr_en = load_acc && (cmd.point_index == 3'(j));

		bdc_cell #(
			.COORD_WIDTH (COORD_WIDTH),
			.T_FRAC_BITS (T_FRAC_BITS)
		) u_cell_x (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_data (cmd.point_x),
			.ctl     (ctl),
			.t       (t_q),
			.nbr     (wx[(j + 1 < NCELL) ? j + 1 : j]),
			.w       (wx[j])
		);

		bdc_cell #(
			.COORD_WIDTH (COORD_WIDTH),
			.T_FRAC_BITS (T_FRAC_BITS)
		) u_cell_y (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_data (cmd.point_y),
			.ctl     (ctl),
			.t       (t_q),
			.nbr     (wy[(j + 1 < NCELL) ? j + 1 : j]),
			.w       (wy[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= DEG_RESET;
		end else if (cfg_we) begin
			deg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (eval_acc) begin
						cnt_q   <= deg_eff;
						state_q <= (deg_eff == '0) ? ST_DONE : ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					cnt_q   <= cnt_q - DEG_W'(1);
					state_q <= (cnt_q == DEG_W'(1)) ? ST_DONE : ST_DIFF;
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			t_q <= t_sat;
		end
		if (res_load) begin
			res_x_q <= wx[0];
			res_y_q <= wy[0];
		end
	end

	assign res.valid   = res_valid_q;
	assign res.curve_x = res_x_q;
	assign res.curve_y = res_y_q;

endmodule

FILE: hw/rtl/bdc_cell.sv
module bdc_cell import bdc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [COORD_WIDTH-1:0] wr_data,
	input  bdc_ctl_t               ctl,
	input  logic [T_FRAC_BITS:0]   t,
	input  logic [COORD_WIDTH-1:0] nbr,
	output logic [COORD_WIDTH-1:0] w
);

	localparam int PROD_W = COORD_WIDTH + T_FRAC_BITS + 1;
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

	logic [COORD_WIDTH-1:0] ctrl_q;
	logic [COORD_WIDTH-1:0] w_q;
	logic [COORD_WIDTH-1:0] mag_q;
	logic                   neg_q;

	logic signed [COORD_WIDTH:0] sub;
	logic [COORD_WIDTH:0]        sub_abs;
	logic [PROD_W-1:0]           prod;
	logic [PROD_W-1:0]           prod_rnd;
	logic [COORD_WIDTH-1:0]      step;

	// neighbor minus own value, one bit wider so it cannot wrap
	assign sub     = $signed({nbr[COORD_WIDTH-1], nbr}) - $signed({w_q[COORD_WIDTH-1], w_q});
	assign sub_abs = sub[COORD_WIDTH] ? (COORD_WIDTH+1)'(-sub) : (COORD_WIDTH+1)'(sub);

	// round half away from zero on the magnitude
	assign prod     = PROD_W'(mag_q) * PROD_W'(t);
	assign prod_rnd = prod + HALF;
	assign step     = prod_rnd[T_FRAC_BITS +: COORD_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (wr_en) begin
			ctrl_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			w_q <= ctrl_q;
		end else if (ctl.upd) begin
			w_q <= neg_q ? (w_q - step) : (w_q + step);
		end
		if (ctl.diff) begin
			mag_q <= sub_abs[COORD_WIDTH-1:0];
			neg_q <= sub[COORD_WIDTH];
		end
	end

	assign w = w_q;

endmodule

FILE: hw/rtl/bdc_checker.sv
module bdc_checker import bdc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cmd_valid,
	input logic                   cmd_ready,
	input logic                   cmd_op,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [COORD_WIDTH-1:0] curve_x,
	input logic [COORD_WIDTH-1:0] curve_y
);

	// a stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(curve_x) && $stable(curve_y))
		else $error("result item changed while stalled");

	// an evaluate leaves the command side busy in the cycle after it is accepted
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_op == OP_EVAL) |=> !cmd_ready)
		else $error("command accepted during evaluation");

	// a load never blocks the command side
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_op == OP_LOAD) |=> cmd_ready)
		else $error("load stalled the command side");

endmodule

bind bezier_de_casteljau_eval bdc_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_bdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_op    (cmd.op),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.curve_x   (res.curve_x),
	.curve_y   (res.curve_y)
);
